@@ src/assert_macros.svh @@
// Assertion helpers, included by vhp_step.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk, held off while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// Checks that cond never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

@@ src/vhp_pkg.sv @@
package vhp_pkg;

  localparam int TOC_ENTRIES = 100;

  localparam logic [31:0] MAGIC_WORD = 32'h58696E67;

  // Parser phases.
  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_FLAGS  = 3'd1;
  localparam logic [2:0] PH_FRAMES = 3'd2;
  localparam logic [2:0] PH_BYTES  = 3'd3;
  localparam logic [2:0] PH_TOC    = 3'd4;
  localparam logic [2:0] PH_SCALE  = 3'd5;
  localparam logic [2:0] PH_WAIT   = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_TOC  = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // Fail stages.
  localparam logic [2:0] STAGE_NONE  = 3'd0;
  localparam logic [2:0] STAGE_MAGIC = 3'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  stage;
    logic [6:0]  toc_index;
    logic [7:0]  toc_value;
    logic [31:0] flags;
    logic [31:0] frames;
    logic [31:0] bytes;
    logic [31:0] scale;
  } result_t;

  // First optional phase after cur whose flag bit is set, else the waiting phase.
  function automatic logic [2:0] next_phase(logic [2:0] cur, logic [3:0] sel);
    logic [2:0] np;
    logic [2:0] p;
    np = PH_WAIT;
    for (int i = 3; i >= 0; i--) begin
      p = PH_FRAMES + 3'(i);
      if (sel[i] && (p > cur)) begin
        np = p;
      end
    end
    return np;
  endfunction

  // The magic phase reports as the magic-or-flags stage; the others report as themselves.
  function automatic logic [2:0] stage_of(logic [2:0] ph);
    return (ph == PH_MAGIC) ? STAGE_MAGIC : ph;
  endfunction

endpackage

@@ src/vbr_header_parser.sv @@
// Channel  Direction  Payload
// in_      slave      tdata[7:0] = data_byte; tlast = last_byte
// out_     master     tuser[1:0] = result_kind; tdata = fail_stage, toc_index, toc_value,
//                     header_flags, frame_count, stream_bytes, scale_value (low bit up)
//
// Bytes stream through the parse step at one per cycle while the output is not stalled.
// An accepted input transaction waits in the input register, and its result is held in the output register.
// rst_n is synchronous and active low; it returns the parser to the magic phase.
// A stalled output holds its result while the input register still takes one more byte.
module vbr_header_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // data_byte[7:0]
  input  logic         in_tlast,    // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,   // fail_stage[2:0], toc_index[9:3], toc_value[17:10],
                                    // header_flags[49:18], frame_count[81:50],
                                    // stream_bytes[113:82], scale_value[145:114], zero pad
  output logic [1:0]   out_tuser    // result_kind[1:0]
);

  logic              item_valid;
  vhp_pkg::in_item_t item;
  logic              out_free;
  logic              step_en;
  logic              res_valid;
  vhp_pkg::result_t  res;
  vhp_pkg::result_t  res_q;

  // A byte is parsed when it sits in the input register and the result register can take
  // whatever it produces. Bytes that produce no result still wait for a free slot, which
  // keeps the control simple and costs nothing while the consumer keeps up.
  assign step_en = item_valid && out_free;

  vhp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .step_en    (step_en),
    .item_valid (item_valid),
    .item       (item)
  );

  // Phase tracking, field assembly and result formation for one byte.
  vhp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  vhp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en && res_valid),
    .res        (res),
    .out_tready (out_tready),
    .out_free   (out_free),
    .out_valid  (out_tvalid),
    .res_q      (res_q)
  );

  // Pack the result fields from the lowest bit up, padded to whole bytes.
  assign out_tdata = {6'd0, res_q.scale, res_q.bytes, res_q.frames, res_q.flags,
                      res_q.toc_value, res_q.toc_index, res_q.stage};
  assign out_tuser = res_q.kind;

endmodule

@@ src/vhp_in_reg.sv @@
module vhp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // data_byte[7:0]
  input  logic              in_tlast,
  input  logic              step_en,
  output logic              item_valid,
  output vhp_pkg::in_item_t item
);

  logic              valid_r;
  logic              valid_nxt;
  vhp_pkg::in_item_t item_r;

  // The register may refill in the same cycle that its item moves on.
  assign in_tready = !valid_r || step_en;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (step_en) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data_byte <= in_tdata;
      item_r.last_byte <= in_tlast;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ src/vhp_step.sv @@
`include "assert_macros.svh"

module vhp_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  vhp_pkg::in_item_t item,
  output logic              res_valid,
  output vhp_pkg::result_t  res
);

  logic [2:0]  phase_r,  phase_nxt;
  logic [6:0]  bif_r,    bif_nxt;
  logic [23:0] asm_r,    asm_nxt;
  logic [31:0] flags_r,  flags_nxt;
  logic [31:0] frames_r, frames_nxt;
  logic [31:0] bytes_r,  bytes_nxt;
  logic [31:0] scale_r,  scale_nxt;

  logic [31:0] word;
  logic [6:0]  bif_inc;
  logic        complete;
  logic [2:0]  np;

  assign word    = {asm_r, item.data_byte};
  assign bif_inc = bif_r + 7'd1;
  assign complete = (phase_r == vhp_pkg::PH_TOC) ? (bif_inc >= 7'(vhp_pkg::TOC_ENTRIES))
                                                 : (bif_inc >= 7'd4);

  always_comb begin
    phase_nxt  = phase_r;
    bif_nxt    = bif_r;
    asm_nxt    = asm_r;
    flags_nxt  = flags_r;
    frames_nxt = frames_r;
    bytes_nxt  = bytes_r;
    scale_nxt  = scale_r;
    res_valid  = 1'b0;
    res        = '0;
    np         = vhp_pkg::PH_WAIT;

    if (phase_r > vhp_pkg::PH_SCALE) begin
      // Skipping the rest of a region after its result.
      if (item.last_byte) begin
        phase_nxt = vhp_pkg::PH_MAGIC;
      end
    end else begin
      asm_nxt = word[23:0];
      bif_nxt = bif_inc;
      if (!complete) begin
        if (item.last_byte) begin
          res_valid = 1'b1;
          res.kind  = vhp_pkg::KIND_FAIL;
          res.stage = vhp_pkg::stage_of(phase_r);
          phase_nxt = vhp_pkg::PH_MAGIC;
        end else if (phase_r == vhp_pkg::PH_TOC) begin
          res_valid     = 1'b1;
          res.kind      = vhp_pkg::KIND_TOC;
          res.toc_index = bif_r;
          res.toc_value = item.data_byte;
        end
      end else if ((phase_r == vhp_pkg::PH_MAGIC) && (word != vhp_pkg::MAGIC_WORD)) begin
        res_valid = 1'b1;
        res.kind  = vhp_pkg::KIND_FAIL;
        res.stage = vhp_pkg::STAGE_MAGIC;
        phase_nxt = item.last_byte ? vhp_pkg::PH_MAGIC : vhp_pkg::PH_WAIT;
      end else begin
        unique case (phase_r)
          vhp_pkg::PH_FLAGS:  flags_nxt  = word;
          vhp_pkg::PH_FRAMES: frames_nxt = word;
          vhp_pkg::PH_BYTES:  bytes_nxt  = word;
          vhp_pkg::PH_SCALE:  scale_nxt  = word;
          default: ;
        endcase
        bif_nxt = '0;
        asm_nxt = '0;
        np = (phase_r == vhp_pkg::PH_MAGIC) ? vhp_pkg::PH_FLAGS
                                            : vhp_pkg::next_phase(phase_r, flags_nxt[3:0]);
        phase_nxt = np;
        if (np == vhp_pkg::PH_WAIT) begin
          res_valid  = 1'b1;
          res.kind   = vhp_pkg::KIND_OK;
          res.flags  = flags_nxt;
          res.frames = frames_nxt;
          res.bytes  = bytes_nxt;
          res.scale  = scale_nxt;
          if (phase_r == vhp_pkg::PH_TOC) begin
            res.toc_index = bif_r;
            res.toc_value = item.data_byte;
          end
          if (item.last_byte) begin
            phase_nxt = vhp_pkg::PH_MAGIC;
          end
        end else if (item.last_byte) begin
          res_valid = 1'b1;
          res.kind  = vhp_pkg::KIND_FAIL;
          res.stage = vhp_pkg::stage_of(np);
          phase_nxt = vhp_pkg::PH_MAGIC;
        end else if (phase_r == vhp_pkg::PH_TOC) begin
          res_valid     = 1'b1;
          res.kind      = vhp_pkg::KIND_TOC;
          res.toc_index = bif_r;
          res.toc_value = item.data_byte;
        end
      end
    end

    // Every marked byte starts the next region from a clean slate.
    if (item.last_byte) begin
      phase_nxt  = vhp_pkg::PH_MAGIC;
      bif_nxt    = '0;
      asm_nxt    = '0;
      flags_nxt  = '0;
      frames_nxt = '0;
      bytes_nxt  = '0;
      scale_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= vhp_pkg::PH_MAGIC;
      bif_r    <= '0;
      asm_r    <= '0;
      flags_r  <= '0;
      frames_r <= '0;
      bytes_r  <= '0;
      scale_r  <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      bif_r    <= bif_nxt;
      asm_r    <= asm_nxt;
      flags_r  <= flags_nxt;
      frames_r <= frames_nxt;
      bytes_r  <= bytes_nxt;
      scale_r  <= scale_nxt;
    end
  end

  logic toc_fire;
  logic end_fire;
  logic last_fire;
  logic clean_start;

  assign toc_fire    = step_en && res_valid && (res.kind == vhp_pkg::KIND_TOC);
  assign end_fire    = step_en && res_valid && (res.kind != vhp_pkg::KIND_TOC) &&
                       !item.last_byte;
  assign last_fire   = step_en && item.last_byte;
  assign clean_start = (phase_r == vhp_pkg::PH_MAGIC) && (bif_r == 7'd0) &&
                       (flags_r == 32'd0);

  `ASSERT_CLK(a_toc_in_toc_phase, clk, rst_n, toc_fire |-> (phase_r == vhp_pkg::PH_TOC))
  `ASSERT_CLK(a_wait_after_result, clk, rst_n, end_fire |=> (phase_r == vhp_pkg::PH_WAIT))
  `ASSERT_CLK(a_restart_on_last, clk, rst_n, last_fire |=> clean_start)

endmodule

@@ src/vhp_out_reg.sv @@
module vhp_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  vhp_pkg::result_t res,
  input  logic             out_tready,
  output logic             out_free,
  output logic             out_valid,
  output vhp_pkg::result_t res_q
);

  logic             valid_r;
  logic             valid_nxt;
  vhp_pkg::result_t res_r;

  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign res_q     = res_r;

endmodule
